[rtl/ppd_pkg.sv]
// Package for the pixel polarisation demodulator.
// Holds item types, table geometry, divider sizes and the leak coefficients.
// No dependencies.
package ppd_pkg;

    localparam int GRID_SIZE  = 32;
    localparam int GRID_W     = $clog2(GRID_SIZE);
    localparam int MAX_FRAMES = 8;
    localparam int FRAME_W    = 3;
    localparam int TBL_AW     = 2 * GRID_W + 2 + FRAME_W;
    localparam int TBL_DEPTH  = 2 ** TBL_AW;

    // Grid position numerator width: GRID*(2x+1) + dim
    localparam int AX_W = 13 + 1 + GRID_W;

    localparam int DIV_NW = 48;
    localparam int DIV_DW = 26;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    localparam logic [1:0] CFG_OUTPUT_MODE  = 2'd0;
    localparam logic [2:0] CFG_IDX_OMODE    = 3'd0;
    localparam logic [2:0] CFG_IDX_LMODE    = 3'd1;
    localparam logic [2:0] CFG_IDX_FCOUNT   = 3'd2;
    localparam logic [2:0] CFG_IDX_WIDTH    = 3'd3;
    localparam logic [2:0] CFG_IDX_HEIGHT   = 3'd4;

    localparam logic [1:0] LEAK_NONE  = 2'd0;
    localparam logic [1:0] LEAK_CONST = 2'd1;
    localparam logic [1:0] LEAK_POLY  = 2'd2;

    localparam logic [1:0] OMODE_ZERO = 2'd0;
    localparam logic [1:0] OMODE_IQUV = 2'd1;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [14:0]         table_index;
        logic signed [31:0]  table_value;
        logic [11:0]         pixel_x;
        logic [11:0]         pixel_y;
        logic [2:0]          frame_number;
        logic signed [23:0]  sample;
        logic                last_frame;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          pol_index;
        logic signed [31:0]  value;
        logic                last;
    } t_out_item;

    typedef struct packed {
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    // Leak coefficients, Q.28. u selects the U row; const mode uses a single term.
    function automatic logic signed [20:0] leak_coef(input logic u, input logic poly,
                                                     input logic [2:0] k);
        logic signed [20:0] c;
        c = 21'sd0;
        if (!poly) begin
            c = u ? 21'sd29528 : 21'sd57714;
        end else begin
            case (k)
                3'd0:    c = u ? -21'sd31686  : 21'sd548;
                3'd1:    c = u ?  21'sd31899  : 21'sd32320;
                3'd2:    c = u ?  21'sd62642  : 21'sd71235;
                3'd3:    c = u ? -21'sd306388 : -21'sd159919;
                3'd4:    c = u ? -21'sd936783 : -21'sd700224;
                default: c = 21'sd0;
            endcase
        end
        return c;
    endfunction

endpackage

[rtl/ppd_div.sv]
// Restoring divider for the demodulator: one quotient bit per cycle.
// Depends on ppd_pkg for the operand widths and request type.
module ppd_div import ppd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quo
);

    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;

    assign trial = {r_rem, r_quo[DIV_NW-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_den  <= i_req.den;
                r_quo  <= i_req.num;
                r_cnt  <= DIV_CW'(DIV_NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
                r_quo <= {r_quo[DIV_NW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[rtl/pixel_polarization_demodulator.sv]
// Pixel polarisation demodulator: a table write leaves it idle; one item at a time.
// A counted sample runs the two grid-position divides, then four single-port table
// reads per polarisation; a last frame then delivers npol results, after up to two
// more divides with polynomial radial leak (constant leak needs none).
// The 48-step divider is shared by all divides; the table has a single read port.
// Reset (synchronous, active low) restores the configuration and state registers
// and clears the accumulators; the table is not cleared. Depends on ppd_pkg and ppd_div.
module pixel_polarization_demodulator import ppd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_DGO, S_DWAIT, S_RD, S_PROD, S_SUM, S_COEF, S_SMP, S_ACC,
        S_FIN, S_LA, S_LB, S_LC, S_LD, S_LEND, S_EMIT
    } t_state;

    t_state r_state;

    logic [1:0]  r_omode, r_lmode;
    logic [3:0]  r_fcount;
    logic [12:0] r_width, r_height;

    logic [11:0]        r_px, r_py;
    logic [2:0]         r_fr;
    logic signed [23:0] r_smp;
    logic               r_last, r_counted;

    logic [1:0]               r_dsel;
    logic [GRID_W-1:0]        r_bx, r_by;
    logic signed [17:0]       r_wx1, r_wy1;
    logic [1:0]               r_p, r_k;
    logic signed [18:0]       r_c;
    logic signed [50:0]       r_prod;
    logic signed [52:0]       r_s;
    logic signed [31:0]       r_coef;
    logic signed [55:0]       r_cs;
    logic signed [47:0]       r_acc [4];
    logic signed [49:0]       r_h [4];
    logic [16:0]              r_sqx;
    logic signed [17:0]       r_rr;
    logic [2:0]               r_lk;
    logic signed [43:0]       r_term;
    logic signed [64:0]       r_lp;
    logic signed [67:0]       r_sumq, r_sumu;

    logic              r_ovalid;
    t_out_item         r_odata;

    logic signed [31:0] mem [TBL_DEPTH];
    logic signed [31:0] r_rdata;

    // Control and status
    logic in_acc, tbl_we, iquv, leak_on, leak_poly, in_counted;
    logic [1:0] last_pol;
    logic [2:0] leak_terms;
    logic out_free;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign tbl_we     = in_acc && (i_in_data.req_type == REQ_WRITE);
    assign iquv       = (r_omode == OMODE_ZERO) || (r_omode == OMODE_IQUV);
    assign last_pol   = iquv ? 2'd3 : 2'd1;
    assign leak_poly  = (r_lmode == LEAK_POLY);
    assign leak_on    = iquv && ((r_lmode == LEAK_CONST) || leak_poly);
    assign leak_terms = leak_poly ? 3'd5 : 3'd1;
    assign in_counted = ({1'b0, i_in_data.frame_number} < r_fcount)
                     && ({1'b0, i_in_data.frame_number} < 4'(MAX_FRAMES));
    assign out_free   = !r_ovalid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Divider operands
    logic [11:0]        d_pos;
    logic [12:0]        d_dim, d_dimc;
    logic [11:0]        d_hh, d_hhc;
    logic [AX_W-1:0]    ax_top;
    logic [AX_W+15:0]   ax_num;
    logic signed [14:0] sd;
    logic signed [29:0] sd2_full;
    logic [25:0]        sd2, sden;
    logic [23:0]        hh2;
    logic [41:0]        sq_num;
    logic               sq_sat, sq_sel;
    t_div_req           div_req;
    logic               div_start, div_done;
    logic [DIV_NW-1:0]  div_quo;

    assign sq_sel   = r_dsel[1];
    assign d_pos    = r_dsel[0] ? r_py : r_px;
    assign d_dim    = r_dsel[0] ? r_height : r_width;
    assign d_dimc   = (d_dim == 13'd0) ? 13'd1 : d_dim;
    assign ax_top   = (AX_W'({d_pos, 1'b1}) << GRID_W) + AX_W'(d_dimc);
    assign ax_num   = {ax_top, 16'b0} + (AX_W+16)'(d_dimc);
    assign d_hh     = d_dim[12:1];
    assign d_hhc    = (d_hh == 12'd0) ? 12'd1 : d_hh;
    assign sd       = $signed({2'b0, d_pos, 1'b1}) - $signed({2'b0, d_hhc, 1'b0});
    assign sd2_full = sd * sd;
    assign sd2      = sd2_full[25:0];
    assign hh2      = d_hhc * d_hhc;
    assign sden     = {hh2, 2'b00};
    assign sq_sat   = sd2 >= sden;
    assign sq_num   = {sd2, 16'b0} + 42'(sden[25:1]);

    always_comb begin
        if (sq_sel) begin
            div_req.num = DIV_NW'(sq_num);
            div_req.den = sden;
        end else begin
            div_req.num = DIV_NW'(ax_num);
            div_req.den = DIV_DW'({d_dimc, 1'b0});
        end
    end

    assign div_start = (r_state == S_DGO) && !(sq_sel && sq_sat);

    ppd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Axis result: q = xi*65536 + 65536
    logic signed [35:0] ax_xi, ax_w1f;
    logic signed [19:0] ax_braw;
    logic [GRID_W-1:0]  ax_b;
    logic signed [17:0] ax_w1;

    assign ax_xi   = $signed({1'b0, div_quo[34:0]}) - 36'sd65536;
    assign ax_braw = $signed({1'b0, div_quo[34:16]}) - 20'sd1;
    always_comb begin
        if (ax_braw < 20'sd0)
            ax_b = '0;
        else if (ax_braw > 20'(GRID_SIZE - 2))
            ax_b = GRID_W'(GRID_SIZE - 2);
        else
            ax_b = ax_braw[GRID_W-1:0];
    end
    assign ax_w1f = ax_xi - $signed({4'b0, ax_b, 16'b0});
    always_comb begin
        if (ax_w1f < -36'sd32768)
            ax_w1 = -18'sd32768;
        else if (ax_w1f > 36'sd98304)
            ax_w1 = 18'sd98304;
        else
            ax_w1 = ax_w1f[17:0];
    end

    // Squares and radius
    logic [16:0]        sq_val;
    logic signed [17:0] rr_val;
    assign sq_val = (r_state == S_DGO) ? 17'd65536 : div_quo[16:0];
    assign rr_val = $signed({1'b0, r_sqx}) + $signed({1'b0, sq_val}) - 18'sd32768;

    // Corner weight and table address
    logic signed [17:0] cw_x, cw_y;
    logic signed [35:0] cw_prod;
    logic signed [36:0] cw_rnd;
    logic [TBL_AW-1:0]  rd_addr;

    assign cw_x    = r_k[0] ? r_wx1 : (18'sd65536 - r_wx1);
    assign cw_y    = r_k[1] ? r_wy1 : (18'sd65536 - r_wy1);
    assign cw_prod = cw_x * cw_y;
    assign cw_rnd  = 37'(cw_prod) + 37'sd32768;
    assign rd_addr = {r_by + GRID_W'(r_k[1]), r_bx + GRID_W'(r_k[0]), r_p, r_fr};

    // Coefficient, product and accumulate
    logic signed [53:0] co_rnd;
    logic signed [37:0] co_sh;
    logic signed [31:0] co_sat;
    logic signed [56:0] cs_rnd;
    logic signed [48:0] acc_sum;
    logic signed [47:0] acc_sat;

    assign co_rnd = 54'(r_s) + 54'sd32768;
    assign co_sh  = 38'(co_rnd >>> 16);
    always_comb begin
        if (co_sh > 38'sd2147483647)
            co_sat = 32'sh7FFFFFFF;
        else if (co_sh < -38'sd2147483648)
            co_sat = 32'sh80000000;
        else
            co_sat = co_sh[31:0];
    end
    assign cs_rnd  = 57'(r_cs) + 57'sd32768;
    assign acc_sum = 49'(r_acc[r_p]) + 49'(cs_rnd >>> 16);
    always_comb begin
        if (acc_sum > 49'sh0_7FFF_FFFF_FFFF)
            acc_sat = 48'sh7FFF_FFFF_FFFF;
        else if (acc_sum < -49'sh0_8000_0000_0000)
            acc_sat = 48'sh8000_0000_0000;
        else
            acc_sat = acc_sum[47:0];
    end

    // Half scale to Q.4
    logic signed [49:0] fin_h [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            fin_h[i] = 50'((49'(r_acc[i]) + 49'sd256) >>> 9);
        end
    end

    // Shared leak multiplier
    logic signed [20:0] lk_a;
    logic signed [64:0] lk_mul;
    logic signed [65:0] lk_trnd;
    logic signed [68:0] lq_rnd, lu_rnd;
    always_comb begin
        case (r_state)
            S_LA:    lk_a = leak_coef(1'b0, leak_poly, r_lk);
            S_LB:    lk_a = leak_coef(1'b1, leak_poly, r_lk);
            default: lk_a = 21'(r_rr);
        endcase
    end
    assign lk_mul  = lk_a * r_term;
    assign lk_trnd = 66'(r_lp) + 66'sd32768;
    assign lq_rnd  = 69'(r_sumq) + 69'sd134217728;
    assign lu_rnd  = 69'(r_sumu) + 69'sd134217728;

    // Output value
    logic signed [50:0] ov_rnd;
    logic signed [46:0] ov_sh;
    logic signed [31:0] ov_sat;
    assign ov_rnd = 51'(r_h[r_p]) + 51'sd8;
    assign ov_sh  = 47'(ov_rnd >>> 4);
    always_comb begin
        if (ov_sh > 47'sd2147483647)
            ov_sat = 32'sh7FFFFFFF;
        else if (ov_sh < -47'sd2147483648)
            ov_sat = 32'sh80000000;
        else
            ov_sat = ov_sh[31:0];
    end

    // Table memory
    always_ff @(posedge i_clk) begin
        if (tbl_we)
            mem[i_in_data.table_index] <= i_in_data.table_value;
        r_rdata <= mem[rd_addr];
    end

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_omode  <= 2'd1;
            r_lmode  <= 2'd0;
            r_fcount <= 4'd6;
            r_width  <= 13'd4096;
            r_height <= 13'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_OMODE:  r_omode  <= i_cfg_data[1:0];
                CFG_IDX_LMODE:  r_lmode  <= i_cfg_data[1:0];
                CFG_IDX_FCOUNT: r_fcount <= i_cfg_data[3:0];
                CFG_IDX_WIDTH:  r_width  <= i_cfg_data;
                CFG_IDX_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 4; i++) r_acc[i] <= '0;
        end else begin
            if (r_ovalid && !i_out_stall)
                r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_in_data.req_type == REQ_SAMPLE)) begin
                        r_px      <= i_in_data.pixel_x;
                        r_py      <= i_in_data.pixel_y;
                        r_fr      <= i_in_data.frame_number;
                        r_smp     <= i_in_data.sample;
                        r_last    <= i_in_data.last_frame;
                        r_counted <= in_counted;
                        r_dsel    <= 2'd0;
                        if (in_counted)
                            r_state <= S_DGO;
                        else if (i_in_data.last_frame)
                            r_state <= S_FIN;
                    end
                end
                S_DGO: begin
                    if (sq_sel && sq_sat) begin
                        // Ratio at or above one: square saturates, skip the divide
                        if (!r_dsel[0]) begin
                            r_sqx  <= sq_val;
                            r_dsel <= 2'd3;
                        end else begin
                            r_rr    <= rr_val;
                            r_state <= S_LA;
                        end
                    end else begin
                        r_state <= S_DWAIT;
                    end
                end
                S_DWAIT: begin
                    if (div_done) begin
                        case (r_dsel)
                            2'd0: begin
                                r_bx    <= ax_b;
                                r_wx1   <= ax_w1;
                                r_dsel  <= 2'd1;
                                r_state <= S_DGO;
                            end
                            2'd1: begin
                                r_by    <= ax_b;
                                r_wy1   <= ax_w1;
                                r_p     <= 2'd0;
                                r_k     <= 2'd0;
                                r_state <= S_RD;
                            end
                            2'd2: begin
                                r_sqx   <= sq_val;
                                r_dsel  <= 2'd3;
                                r_state <= S_DGO;
                            end
                            default: begin
                                r_rr    <= rr_val;
                                r_state <= S_LA;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_c     <= cw_rnd[34:16];
                    r_state <= S_PROD;
                end
                S_PROD: begin
                    r_prod  <= r_c * r_rdata;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_s <= ((r_k == 2'd0) ? 53'sd0 : r_s) + 53'(r_prod);
                    r_k <= r_k + 2'd1;
                    r_state <= (r_k == 2'd3) ? S_COEF : S_RD;
                end
                S_COEF: begin
                    r_coef  <= co_sat;
                    r_state <= S_SMP;
                end
                S_SMP: begin
                    r_cs    <= r_coef * r_smp;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc[r_p] <= acc_sat;
                    r_p <= r_p + 2'd1;
                    if (r_p != last_pol)
                        r_state <= S_RD;
                    else if (r_last)
                        r_state <= S_FIN;
                    else
                        r_state <= S_IDLE;
                end
                S_FIN: begin
                    for (int i = 0; i < 4; i++) begin
                        r_h[i]   <= fin_h[i];
                        r_acc[i] <= '0;
                    end
                    r_term <= 44'(fin_h[0]);
                    r_lk   <= 3'd0;
                    r_sumq <= '0;
                    r_sumu <= '0;
                    r_p    <= 2'd0;
                    r_dsel <= 2'd2;
                    if (!leak_on)
                        r_state <= S_EMIT;
                    else if (leak_poly)
                        r_state <= S_DGO;
                    else
                        r_state <= S_LA;
                end
                S_LA: begin
                    r_lp    <= lk_mul;
                    r_state <= S_LB;
                end
                S_LB: begin
                    r_sumq  <= r_sumq + 68'(r_lp);
                    r_lp    <= lk_mul;
                    r_state <= S_LC;
                end
                S_LC: begin
                    r_sumu  <= r_sumu + 68'(r_lp);
                    r_lp    <= lk_mul;
                    r_state <= S_LD;
                end
                S_LD: begin
                    r_term  <= 44'(lk_trnd >>> 16);
                    r_lk    <= r_lk + 3'd1;
                    r_state <= (r_lk + 3'd1 == leak_terms) ? S_LEND : S_LA;
                end
                S_LEND: begin
                    r_h[1]  <= r_h[1] - 50'(lq_rnd >>> 28);
                    r_h[2]  <= r_h[2] - 50'(lu_rnd >>> 28);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid          <= 1'b1;
                        r_odata.pol_index <= r_p;
                        r_odata.value     <= ov_sat;
                        r_odata.last      <= (r_p == last_pol);
                        r_p               <= r_p + 2'd1;
                        if (r_p == last_pol)
                            r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

`ifndef ASSERT_OFF
    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_we |=> (r_state == S_IDLE))
        else $error("table write did not leave the block ready");

    a_skip_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.req_type == REQ_SAMPLE) && !in_counted
         && !i_in_data.last_frame) |=> (r_state == S_IDLE))
        else $error("uncounted sample did not return to idle");

    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_acc[0] == 48'sd0 && r_acc[1] == 48'sd0
                                && r_acc[2] == 48'sd0 && r_acc[3] == 48'sd0))
        else $error("accumulators not cleared after last frame");

    a_pol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC || r_state == S_EMIT) |-> (iquv || r_p < 2'd2))
        else $error("polarisation index beyond result count");
`endif

endmodule
